FILE: rtl/lut3d_tetrahedral_interp_top_macros.svh
// Assertion helpers for the 3D LUT block.
`ifndef LUT3D_TETRAHEDRAL_INTERP_TOP_MACROS_SVH
`define LUT3D_TETRAHEDRAL_INTERP_TOP_MACROS_SVH

// Clocked check, off while reset is asserted.
`define LUT3D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lut3d check failed");

// Clocked check that also holds across reset.
`define LUT3D_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lut3d reset check failed");

`endif

FILE: rtl/lut3d_pkg.sv
package lut3d_pkg;

  localparam int GRID_POINTS = 33;
  localparam int DEPTH       = GRID_POINTS * GRID_POINTS * GRID_POINTS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int IDX_W       = $clog2(GRID_POINTS);
  localparam int PROD_W      = 8 + IDX_W;
  localparam int ENT_W       = 24;

  typedef enum logic [2:0] {
    TET_1, TET_2, TET_3, TET_4, TET_5, TET_6
  } tet_e;

  // corner codes: bit2 red high, bit1 green high, bit0 blue high
  localparam logic [2:0] CORNER_HI = 3'd7;

  typedef struct packed {
    logic              bypass;
    logic [ENT_W-1:0]  pix;
    logic [7:0]        w1;   // weight of edge base->single
    logic [7:0]        w2;   // weight of edge single->double
    logic [7:0]        w3;   // weight of edge double->far
  } blend_ctl_t;

  typedef struct packed {
    blend_ctl_t        ctl;
    logic [IDX_W-1:0]  lo_r;
    logic [IDX_W-1:0]  lo_g;
    logic [IDX_W-1:0]  lo_b;
    logic [2:0]        cs;
    logic [2:0]        cd;
  } prep_t;

  function automatic logic [ADDR_W-1:0] corner_off(input logic [2:0] k);
    logic [ADDR_W-1:0] o;
    o = '0;
    if (k[2]) o = o + ADDR_W'(1);
    if (k[1]) o = o + ADDR_W'(GRID_POINTS);
    if (k[0]) o = o + ADDR_W'(GRID_POINTS * GRID_POINTS);
    return o;
  endfunction

endpackage

FILE: rtl/lut3d_ram.sv
module lut3d_ram
  import lut3d_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ENT_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr0_i,
  input  logic [ADDR_W-1:0] raddr1_i,
  output logic [ENT_W-1:0]  rdata0_o,
  output logic [ENT_W-1:0]  rdata1_o
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

FILE: rtl/lut3d_prep.sv
module lut3d_prep
  import lut3d_pkg::*;
(
  input  logic [ENT_W-1:0] pix_i,
  input  logic             enable_i,
  output prep_t            prep_o
);

  logic [PROD_W-1:0] prod [3];
  logic [7:0]        fr, fg, fb;
  tet_e              tet;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(pix_i[8*ch +: 8]) * PROD_W'(GRID_POINTS - 1);
    end
    // fraction is the low eight bits of each product; compare on those
    fr = prod[0][7:0];
    fg = prod[1][7:0];
    fb = prod[2][7:0];

    if (fr > fg && fg >= fb)      tet = TET_1;
    else if (fr >= fb && fb > fg) tet = TET_2;
    else if (fb >= fr && fr >= fg) tet = TET_3;
    else if (fg >= fr && fr > fb) tet = TET_4;
    else if (fg > fb && fb >= fr) tet = TET_5;
    else                          tet = TET_6;

    prep_o.ctl.bypass = !enable_i;
    prep_o.ctl.pix    = pix_i;
    prep_o.lo_r       = prod[0][PROD_W-1:8];
    prep_o.lo_g       = prod[1][PROD_W-1:8];
    prep_o.lo_b       = prod[2][PROD_W-1:8];

    unique case (tet)
      TET_1: begin
        prep_o.cs = 3'd4; prep_o.cd = 3'd6;
        prep_o.ctl.w1 = fr; prep_o.ctl.w2 = fg; prep_o.ctl.w3 = fb;
      end
      TET_2: begin
        prep_o.cs = 3'd4; prep_o.cd = 3'd5;
        prep_o.ctl.w1 = fr; prep_o.ctl.w2 = fb; prep_o.ctl.w3 = fg;
      end
      TET_3: begin
        prep_o.cs = 3'd1; prep_o.cd = 3'd5;
        prep_o.ctl.w1 = fb; prep_o.ctl.w2 = fr; prep_o.ctl.w3 = fg;
      end
      TET_4: begin
        prep_o.cs = 3'd2; prep_o.cd = 3'd6;
        prep_o.ctl.w1 = fg; prep_o.ctl.w2 = fr; prep_o.ctl.w3 = fb;
      end
      TET_5: begin
        prep_o.cs = 3'd2; prep_o.cd = 3'd3;
        prep_o.ctl.w1 = fg; prep_o.ctl.w2 = fb; prep_o.ctl.w3 = fr;
      end
      default: begin
        prep_o.cs = 3'd1; prep_o.cd = 3'd3;
        prep_o.ctl.w1 = fb; prep_o.ctl.w2 = fg; prep_o.ctl.w3 = fr;
      end
    endcase
  end

endmodule

FILE: rtl/lut3d_blend.sv
module lut3d_blend
  import lut3d_pkg::*;
(
  input  blend_ctl_t       ctl_i,
  input  logic [ENT_W-1:0] v0_i,
  input  logic [ENT_W-1:0] vs_i,
  input  logic [ENT_W-1:0] vd_i,
  input  logic [ENT_W-1:0] v7_i,
  output logic [ENT_W-1:0] pix_o
);

  logic signed [8:0]  e1 [3];
  logic signed [8:0]  e2 [3];
  logic signed [8:0]  e3 [3];
  logic signed [19:0] acc [3];
  logic signed [11:0] sh [3];
  logic signed [12:0] val [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      e1[ch] = $signed({1'b0, vs_i[8*ch +: 8]}) - $signed({1'b0, v0_i[8*ch +: 8]});
      e2[ch] = $signed({1'b0, vd_i[8*ch +: 8]}) - $signed({1'b0, vs_i[8*ch +: 8]});
      e3[ch] = $signed({1'b0, v7_i[8*ch +: 8]}) - $signed({1'b0, vd_i[8*ch +: 8]});
      acc[ch] = 20'(e1[ch] * $signed({1'b0, ctl_i.w1}))
              + 20'(e2[ch] * $signed({1'b0, ctl_i.w2}))
              + 20'(e3[ch] * $signed({1'b0, ctl_i.w3}))
              + 20'sd128;
      sh[ch]  = 12'(acc[ch] >>> 8);   // floor
      val[ch] = 13'($signed({1'b0, v0_i[8*ch +: 8]})) + 13'(sh[ch]);
      if (ctl_i.bypass)        pix_o[8*ch +: 8] = ctl_i.pix[8*ch +: 8];
      else if (val[ch] < 0)    pix_o[8*ch +: 8] = 8'd0;
      else if (val[ch] > 255)  pix_o[8*ch +: 8] = 8'd255;
      else                     pix_o[8*ch +: 8] = val[ch][7:0];
    end
  end

endmodule

FILE: rtl/lut3d_tetrahedral_interp_top.sv
// Path: a pixel request passes the index register (loaded at the accepting edge),
// the table read registers and the blend/clamp into the output register.
// Throughput: one request per cycle, loads and pixels alike, unless the output
// stalls; the table is held twice, each copy read at two addresses, so four
// corners come out per cycle. Reset: pipeline valids clear and enable returns
// to 1; table contents stay undefined until loaded.
module lut3d_tetrahedral_interp_top
  import lut3d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: lut_addr[15:0] lut_red[23:16] lut_green[31:24] lut_blue[39:32]
  //        pix_red[47:40] pix_green[55:48] pix_blue[63:56]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,
  // tuser: func[0] (0 load entry, 1 pixel)
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: out_red[7:0] out_green[15:8] out_blue[23:16]
  output logic [23:0] m_axis_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic enable_q;

  logic       v1_q, v2_q, v3_q;
  logic       rdy1, rdy2, rdy3;
  prep_t      prep, s1_q;
  blend_ctl_t s2_q;
  logic [ENT_W-1:0] blend_pix, out_q;

  logic              acc_req, load_req;
  logic              tab_we;
  logic [ADDR_W-1:0] base, a0, a7, as_, ad;
  logic [ENT_W-1:0]  v0, v7, vs, vd;

  // config: enable is the only register, decoded at every address with paddr[2] low
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == 1'b0) ? {31'd0, enable_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == 1'b0) begin
      enable_q <= pwdata_i[0];
    end
  end

  // elastic pipeline: each stage takes when empty or draining
  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  assign acc_req  = s_axis_tvalid_i && s_axis_tready_o;
  assign load_req = acc_req && !s_axis_tuser_i;
  // out-of-range loads are dropped
  assign tab_we   = load_req && ({16'd0, s_axis_tdata_i[15:0]} < 32'(DEPTH));

  lut3d_prep u_prep (
    .pix_i    (s_axis_tdata_i[63:40]),
    .enable_i (enable_q),
    .prep_o   (prep)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= acc_req && s_axis_tuser_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= prep;
    if (rdy2) s2_q <= s1_q.ctl;
    if (rdy3) out_q <= blend_pix;
  end

  // corner addresses; lo indices never exceed N-2 so the far corner is in range
  assign base = ADDR_W'(s1_q.lo_r)
              + ADDR_W'(s1_q.lo_g) * ADDR_W'(GRID_POINTS)
              + ADDR_W'(s1_q.lo_b) * ADDR_W'(GRID_POINTS * GRID_POINTS);
  assign a0  = base;
  assign a7  = base + corner_off(CORNER_HI);
  assign as_ = base + corner_off(s1_q.cs);
  assign ad  = base + corner_off(s1_q.cd);

  // Both copies take every load; a write and a read of the same entry in one
  // edge only happens when the pixel ahead of the load reads, so old data is right.
  lut3d_ram u_ram_a (
    .clk_i    (clk_i),
    .we_i     (tab_we),
    .waddr_i  (s_axis_tdata_i[ADDR_W-1:0]),
    .wdata_i  (s_axis_tdata_i[39:16]),
    .re_i     (rdy2),
    .raddr0_i (a0),
    .raddr1_i (a7),
    .rdata0_o (v0),
    .rdata1_o (v7)
  );

  lut3d_ram u_ram_b (
    .clk_i    (clk_i),
    .we_i     (tab_we),
    .waddr_i  (s_axis_tdata_i[ADDR_W-1:0]),
    .wdata_i  (s_axis_tdata_i[39:16]),
    .re_i     (rdy2),
    .raddr0_i (as_),
    .raddr1_i (ad),
    .rdata0_o (vs),
    .rdata1_o (vd)
  );

  lut3d_blend u_blend (
    .ctl_i (s2_q),
    .v0_i  (v0),
    .vs_i  (vs),
    .vd_i  (vd),
    .v7_i  (v7),
    .pix_o (blend_pix)
  );

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = out_q;

endmodule

FILE: rtl/lut3d_chk.sv
`include "lut3d_tetrahedral_interp_top_macros.svh"

module lut3d_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic [2:0]  paddr_i,
  input logic [31:0] pwdata_i,
  input logic [31:0] prdata_o,
  input logic        pready_o
);

  `LUT3D_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
  `LUT3D_ASSERT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
  `LUT3D_ASSERT(a_cfg_rdback, psel_i && penable_i && pwrite_i && pready_o && paddr_i[2] == 1'b0 |=> paddr_i[2] != 1'b0 || prdata_o[0] == $past(pwdata_i[0]))
  `LUT3D_ASSERT_ALWAYS(a_rst_empty, $rose(rst_ni) |-> !m_axis_tvalid_o)

endmodule

bind lut3d_tetrahedral_interp_top lut3d_chk u_lut3d_chk (.*);
